/* design/fpc_pkg.sv */
package fpc_pkg;

    localparam int NUM_SWITCHES_DEF = 2;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam int HOLD_W = 16;
    localparam int WINDOW_W = 16;
    localparam int TIME_W = 32;
    localparam int TALLY_W = 8;
    localparam int MASK_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    localparam logic [HOLD_W-1:0] HOLD_RST = 16'd1000;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd500;
    localparam logic [MASK_W-1:0] MASK_RST = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EVENTS_ENABLED = 2'd0,
        CFG_HOLD_MS = 2'd1,
        CFG_DOUBLE_WINDOW_MS = 2'd2,
        CFG_EVENT_MASK = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_NORMAL = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG = 2'd3
    } ev_t;

    localparam int MASK_NORMAL_BIT = 0;
    localparam int MASK_DOUBLE_BIT = 1;
    localparam int MASK_LONG_BIT = 2;

    typedef struct packed {
        logic events_enabled;
        logic [HOLD_W-1:0] hold_ms;
        logic [WINDOW_W-1:0] double_window_ms;
        logic [MASK_W-1:0] event_mask;
    } cfg_t;

    typedef struct packed {
        logic active;
        logic switch_index;
        logic level;
        logic [TIME_W-1:0] now_ms;
    } item_t;

endpackage

/* design/fpc_front.sv */
module fpc_front
    import fpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 events_enabled,
    output logic                 push,
    output item_t                push_item,
    input  logic                 queue_full
);

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
    localparam int CMP_W = IDX_W + 1;

    logic [CMP_W-1:0] sw_ext;
    logic             in_range;

    // an index beyond the fitted switches is passed on as an inactive sample
    assign sw_ext   = CMP_W'(s_tuser);
    assign in_range = sw_ext < CMP_W'(NUM_SWITCHES);

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_item.active       = events_enabled && in_range;
        push_item.switch_index = s_tuser;
        push_item.level        = s_tdata[0];
        push_item.now_ms       = s_tdata[TIME_W:1];
    end

endmodule

/* design/fpc_queue.sv */
module fpc_queue
    import fpc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head_item,
    output logic  not_empty
);

    item_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == Q_CNT_W'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/fpc_back.sv */
module fpc_back
    import fpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    logic               prev_level_reg  [NUM_SWITCHES];
    logic [TIME_W-1:0]  press_start_reg [NUM_SWITCHES];
    logic [TIME_W-1:0]  last_press_reg  [NUM_SWITCHES];
    logic [TALLY_W-1:0] press_tally_reg [NUM_SWITCHES];
    logic               long_fired_reg  [NUM_SWITCHES];

    logic out_valid_reg, out_valid_next;
    ev_t  ev_reg, ev_next;
    logic sw_reg;

    logic [IDX_W-1:0]   idx;
    logic               prev_lvl, press_edge, in_window, hold_hit;
    logic               fire_long, release_evt, is_double, is_normal, tally_ge2;
    logic [TIME_W-1:0]  gap, dur, start_q, last_q;
    logic [TALLY_W-1:0] tally_q, tally_a, tally_b;
    logic               long_a, long_b;
    logic               upd;

    assign idx = IDX_W'(item.switch_index);
    assign pop = item_valid && (!out_valid_reg || m_tready);
    assign upd = pop && item.active;

    always_comb begin
        prev_lvl   = prev_level_reg[idx];
        start_q    = press_start_reg[idx];
        last_q     = last_press_reg[idx];
        tally_q    = press_tally_reg[idx];
        press_edge = item.level && !prev_lvl;

        gap       = item.now_ms - last_q;
        in_window = gap <= TIME_W'(cfg.double_window_ms);
        if (!press_edge) begin
            tally_a = tally_q;
        end else if (!in_window) begin
            tally_a = TALLY_W'(1);
        end else if (tally_q == TALLY_MAX) begin
            tally_a = tally_q;
        end else begin
            tally_a = tally_q + 1'b1;
        end
        long_a = press_edge ? 1'b0 : long_fired_reg[idx];

        // a fresh press starts its duration at zero
        dur      = press_edge ? '0 : item.now_ms - start_q;
        hold_hit = dur >= TIME_W'(cfg.hold_ms);

        fire_long   = item.level && hold_hit && !long_a;
        long_b      = long_a || fire_long;
        release_evt = !item.level && prev_lvl && !long_a;
        tally_ge2   = tally_a >= TALLY_W'(2);
        is_double   = release_evt && tally_ge2;
        is_normal   = release_evt && !tally_ge2 && !hold_hit;
        tally_b     = is_double ? '0 : tally_a;

        ev_next = EV_NONE;
        if (item.active) begin
            if (fire_long && cfg.event_mask[MASK_LONG_BIT]) begin
                ev_next = EV_LONG;
            end else if (is_double && cfg.event_mask[MASK_DOUBLE_BIT]) begin
                ev_next = EV_DOUBLE;
            end else if (is_normal && cfg.event_mask[MASK_NORMAL_BIT]) begin
                ev_next = EV_NORMAL;
            end
        end

        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                prev_level_reg[i]  <= 1'b0;
                press_start_reg[i] <= '0;
                last_press_reg[i]  <= '0;
                press_tally_reg[i] <= '0;
                long_fired_reg[i]  <= 1'b0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            if (upd) begin
                prev_level_reg[idx]  <= item.level;
                press_start_reg[idx] <= press_edge ? item.now_ms : start_q;
                last_press_reg[idx]  <= press_edge ? item.now_ms : last_q;
                press_tally_reg[idx] <= tally_b;
                long_fired_reg[idx]  <= long_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ev_reg <= ev_next;
            sw_reg <= item.switch_index;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(ev_reg);
    assign m_tuser  = sw_reg;

endmodule

/* design/footswitch_press_classifier.sv */
// channel  | direction | tdata bits, low first              | tuser
// s_       | in        | level [0], now_ms [32:1], zero pad | switch_index
// m_       | out       | event_res [1:0], zero pad          | event_switch
// cfg_     | in        | write only, index then data        | -
//
// one sample per clock sustained while m_tready stays high; each sample gives exactly one result beat
// m_tvalid rises after a sample is taken: the sample is written to the queue at the
// taking edge, then the per-switch read-modify-write in the back end pops it and loads
// the output register, which waits while an unaccepted result is still held
// s_tready drops only when the two-entry queue is full, i.e. after m_tready
// has been low for long enough
// synchronous active-low reset clears config to defaults and all switch state
module footswitch_press_classifier
    import fpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // level, now_ms, pad
    input  logic                  s_tuser,   // switch_index

    // event stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // event_res, pad
    output logic                  m_tuser    // event_switch
);

    cfg_t  cfg_reg, cfg_next;
    logic  push, queue_full, pop, queue_valid;
    item_t push_item, head_item;

    // config registers; the user must write them only while the block is idle, the block does not enforce this
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_EVENTS_ENABLED:   cfg_next.events_enabled   = cfg_wdata[0];
                CFG_HOLD_MS:          cfg_next.hold_ms          = cfg_wdata[HOLD_W-1:0];
                CFG_DOUBLE_WINDOW_MS: cfg_next.double_window_ms = cfg_wdata[WINDOW_W-1:0];
                CFG_EVENT_MASK:       cfg_next.event_mask       = cfg_wdata[MASK_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.events_enabled   <= 1'b0;
            cfg_reg.hold_ms          <= HOLD_RST;
            cfg_reg.double_window_ms <= WINDOW_RST;
            cfg_reg.event_mask       <= MASK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: takes samples, marks each active or ignored
    fpc_front #(
        .NUM_SWITCHES(NUM_SWITCHES)
    ) u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .events_enabled (cfg_reg.events_enabled),
        .push           (push),
        .push_item      (push_item),
        .queue_full     (queue_full)
    );

    // short queue decoupling intake from the state update
    fpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (queue_valid)
    );

    // back: per-switch state update and event output register
    fpc_back #(
        .NUM_SWITCHES(NUM_SWITCHES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item       (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* sim/tb.sv */
module tb;
    import fpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSW         = NUM_SWITCHES_DEF;
    localparam int CYCLE_LIMIT = 500000;

    // one expected result beat: the event kind and the switch it refers to
    typedef struct {
        ev_t  ev;
        logic sw;
    } event_exp_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_EVENTS_ENABLED;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // level, now_ms, zero pad
    logic                  s_tuser   = 1'b0; // switch_index
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // event_res, zero pad
    logic                  m_tuser;          // event_switch

    footswitch_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // press classifier shadow: configuration and per-switch state
    // ------------------------------------------------------------------
    logic              cfg_en     = 1'b0;
    logic [HOLD_W-1:0] cfg_hold   = HOLD_RST;
    logic [WINDOW_W-1:0] cfg_window = WINDOW_RST;
    logic [MASK_W-1:0] cfg_mask   = MASK_RST;

    logic               sw_prev  [NSW] = '{default: 1'b0};
    logic [TIME_W-1:0]  sw_start [NSW] = '{default: '0};
    logic [TIME_W-1:0]  sw_last  [NSW] = '{default: '0};
    logic [TALLY_W-1:0] sw_tally [NSW] = '{default: '0};
    logic               sw_long  [NSW] = '{default: 1'b0};

    event_exp_t pending_events[$];
    event_exp_t got_exp;

    int          n_errors  = 0;
    int          n_cycles  = 0;
    int unsigned n_sent    = 0;
    logic [TIME_W-1:0] t_ms = '0;   // running millisecond clock of the stimulus

    // sender burst bookkeeping
    logic tx_live  = 1'b0;
    int   tx_burst = 0;
    int   tx_gap   = 1;

    // receiver stall bookkeeping; hold_req asks for a long hold-off
    int   hold_req  = 0;
    int   hold_left = 0;
    int   rx_left   = 0;
    logic rx_on     = 1'b0;

    // works out the event for one accepted sample and updates the shadow state
    function automatic ev_t classify(input logic sw, input logic lvl,
                                     input logic [TIME_W-1:0] now);
        ev_t               ev = EV_NONE;
        logic [TIME_W-1:0] held;
        if (!cfg_en || int'(sw) >= NSW)
            return EV_NONE;

        // press edge: restart the hold timer and count toward a double
        if (lvl && !sw_prev[sw]) begin
            sw_start[sw] = now;
            if (TIME_W'(now - sw_last[sw]) <= TIME_W'(cfg_window)) begin
                if (sw_tally[sw] != TALLY_MAX)
                    sw_tally[sw] = sw_tally[sw] + 1'b1;
            end else begin
                sw_tally[sw] = TALLY_W'(1);
            end
            sw_last[sw] = now;
            sw_long[sw] = 1'b0;
        end

        held = now - sw_start[sw];

        // held long enough: one long press per hold, even when masked
        if (lvl && held >= TIME_W'(cfg_hold) && !sw_long[sw]) begin
            if (cfg_mask[MASK_LONG_BIT])
                ev = EV_LONG;
            sw_long[sw] = 1'b1;
        end

        // release without a long press: double wins over normal
        if (!lvl && sw_prev[sw] && !sw_long[sw]) begin
            if (sw_tally[sw] >= 2) begin
                if (cfg_mask[MASK_DOUBLE_BIT])
                    ev = EV_DOUBLE;
                sw_tally[sw] = '0;
            end else if (held < TIME_W'(cfg_hold)) begin
                if (cfg_mask[MASK_NORMAL_BIT])
                    ev = EV_NORMAL;
            end
        end

        sw_prev[sw] = lvl;
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: stall pattern of its own, plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        // a beat moves at this edge when both were high before it
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: event beat with nothing expected, got res=%0d sw=%0d",
                         $time, m_tdata[1:0], m_tuser);
                n_errors++;
            end else begin
                got_exp = pending_events.pop_front();
                if (m_tdata[1:0] !== got_exp.ev) begin
                    $display("%0t: event_res expected %0d got %0d", $time,
                             got_exp.ev, m_tdata[1:0]);
                    n_errors++;
                end
                if (m_tuser !== got_exp.sw) begin
                    $display("%0t: event_switch expected %0d got %0d", $time,
                             got_exp.sw, m_tuser);
                    n_errors++;
                end
            end
        end

        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            // long hold-off, counted here so the sender keeps offering
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_on = !rx_on;
                if (rx_on)
                    rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                          : $urandom_range(1, 24);
                else
                    rx_left = $urandom_range(0, 6);
            end else begin
                rx_left--;
            end
            m_tready <= rx_on;
        end
    end

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------

    // offers one sample beat and waits for it to be taken; bursts of random
    // length, with a gap between them
    task automatic send_sample(input logic sw, input logic lvl,
                               input logic [TIME_W-1:0] now);
        event_exp_t e;
        if (!tx_live) begin
            repeat (tx_gap) @(posedge aclk);
            tx_burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-TIME_W-1){1'b0}}, now, lvl};
        s_tuser  <= sw;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_tready);
        e.ev = classify(sw, lvl, now);
        e.sw = sw;
        pending_events.push_back(e);
        n_sent++;
        tx_burst--;
        if (tx_burst <= 0) begin
            s_tvalid <= 1'b0;
            tx_live = 1'b0;
            tx_gap  = $urandom_range(1, 8);
        end
    endtask

    // stop offering, then wait for every expected beat and a little more
    task automatic settle_block();
        if (tx_live) begin
            s_tvalid <= 1'b0;
            tx_live  = 1'b0;
            tx_burst = 0;
            tx_gap   = 1;
        end
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EVENTS_ENABLED:   cfg_en     = val[0];
            CFG_HOLD_MS:          cfg_hold   = val[HOLD_W-1:0];
            CFG_DOUBLE_WINDOW_MS: cfg_window = val[WINDOW_W-1:0];
            CFG_EVENT_MASK:       cfg_mask   = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic en, input logic [HOLD_W-1:0] hold,
                             input logic [WINDOW_W-1:0] win, input logic [MASK_W-1:0] mask);
        settle_block();
        write_reg(CFG_EVENTS_ENABLED, CFG_DATA_W'(en));
        write_reg(CFG_HOLD_MS, hold);
        write_reg(CFG_DOUBLE_WINDOW_MS, win);
        write_reg(CFG_EVENT_MASK, CFG_DATA_W'(mask));
    endtask

    // one press: gap ms of rest, press, some held beats, release after len ms
    task automatic tap(input logic sw, input int unsigned gap, input int unsigned len,
                       input int unsigned holds);
        int unsigned stride;
        stride = len / (holds + 1);
        t_ms += gap;
        send_sample(sw, 1'b1, t_ms);
        repeat (holds) begin
            t_ms += stride;
            send_sample(sw, 1'b1, t_ms);
        end
        t_ms += len - stride * holds;
        send_sample(sw, 1'b0, t_ms);
    endtask

    // press length clustered around the hold time
    function automatic int unsigned pick_len();
        int unsigned h = cfg_hold;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, h);
            1: return (h == 0) ? 0 : h - 1;
            2: return h;
            3: return h + 1;
            4: return h + $urandom_range(1, 3000);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // rest between presses clustered around the double window
    function automatic int unsigned pick_gap();
        int unsigned w = cfg_window;
        case ($urandom_range(0, 6))
            0: return 0;
            1: return $urandom_range(0, w / 2);
            2: return w;
            3: return w + 1;
            4: return w + $urandom_range(1, 5000);
            5: return $urandom;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // out of reset the block is disabled: a full press gives nothing
    task automatic test_disabled();
        tap(1'b0, 5, 10, 0);
    endtask

    task automatic test_single_events();
        configure(1'b1, 100, 50, 3'b111);
        tap(1'b0, 1000, 10, 0);     // short press: normal on release
        tap(1'b1, 1000, 200, 1);    // held beat at exactly the hold time: long
        tap(1'b0, 1000, 0, 0);      // press and release in the same ms
        tap(1'b0, 50, 0, 0);        // second press right at the window edge: double
    endtask

    // masked kinds still update the state as if reported
    task automatic test_masked_events();
        configure(1'b1, 100, 50, 3'b001);
        tap(1'b1, 1000, 150, 1);    // held past the hold time with no beat there, release must stay silent
        tap(1'b0, 1000, 5, 0);
        tap(1'b0, 10, 5, 0);        // double masked, tally still cleared
        tap(1'b0, 10, 5, 0);        // tally restarts, so this is a normal press
    endtask

    // zero hold time: long press on the very first pressed beat
    task automatic test_zero_hold();
        configure(1'b1, 0, 50, 3'b111);
        tap(1'b1, 1000, 5, 0);
    endtask

    // timestamps crossing the 32-bit wrap
    task automatic test_time_wrap();
        configure(1'b1, 100, 50, 3'b111);
        t_ms = 32'hFFFF_FFF0;
        tap(1'b0, 0, 40, 0);
        tap(1'b0, 5, 0, 0);
    endtask

    // tally must stick at its maximum: with zero hold every release is
    // swallowed by the long press, so the tally only climbs
    task automatic test_tally_saturation();
        configure(1'b1, 0, 16'hFFFF, 3'b111);
        t_ms += 70000;
        repeat (256) tap(1'b1, 3, 1, 0);
        settle_block();
        write_reg(CFG_HOLD_MS, 16'hFFFF);
        tap(1'b1, 3, 1, 0);         // tally still high: double on release
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        configure(1'b1, 50, 30, 3'b111);
        hold_req = 300;
        repeat (20) tap(1'($urandom_range(0, 1)), pick_gap(), pick_len(),
                        $urandom_range(0, 2));
    endtask

    // phases of random settings, mostly well-formed presses with random timing
    task automatic test_random_traffic();
        int unsigned first;
        int unsigned quota;
        logic        a;
        logic        en;
        logic [HOLD_W-1:0]   hold;
        logic [WINDOW_W-1:0] win;
        logic [MASK_W-1:0]   mask;
        for (int ph = 0; ph < 11; ph++) begin
            en   = 1'b1;
            hold = HOLD_W'($urandom_range(1, 400));
            win  = WINDOW_W'($urandom_range(0, 400));
            mask = MASK_W'($urandom_range(0, 7));
            case (ph)
                0: begin hold = 16'hFFFF; win = 16'hFFFF; mask = 3'b111; end
                1: begin hold = 1; win = 0; end
                2: hold = 0;
                3: en = 1'b0;
                4: mask = 3'b000;
                default: ;
            endcase
            configure(en, hold, win, mask);
            quota = en ? 140 : 30;
            first = n_sent;
            while (n_sent - first < quota) begin
                case ($urandom_range(0, 11))
                    0: send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 1) ? $urandom : t_ms);
                    1: begin
                        // lone edge: press with no release or release with no press
                        t_ms += pick_gap();
                        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    t_ms);
                    end
                    2: begin
                        // both switches down at once, released in order
                        a = 1'($urandom_range(0, 1));
                        t_ms += pick_gap();
                        send_sample(a, 1'b1, t_ms);
                        t_ms += $urandom_range(0, cfg_hold);
                        send_sample(!a, 1'b1, t_ms);
                        t_ms += pick_len();
                        send_sample(a, 1'b0, t_ms);
                        t_ms += $urandom_range(0, 50);
                        send_sample(!a, 1'b0, t_ms);
                    end
                    default: tap(1'($urandom_range(0, 1)), pick_gap(), pick_len(),
                                 $urandom_range(0, 3));
                endcase
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled();
        test_single_events();
        test_masked_events();
        test_zero_hold();
        test_time_wrap();
        test_tally_saturation();
        test_backpressure();
        test_random_traffic();

        settle_block();
        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
design/fpc_pkg.sv
design/fpc_front.sv
design/fpc_queue.sv
design/fpc_back.sv
design/footswitch_press_classifier.sv
sim/tb.sv
